// ----- hw/rtl/gdsrd_pkg.sv -----
`timescale 1ns / 1ps

package gdsrd_pkg;

  localparam logic [2:0] ST_ELEM     = 3'd0;
  localparam logic [2:0] ST_END      = 3'd1;
  localparam logic [2:0] ST_EOF_HDR  = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_BADLEN   = 3'd4;
  localparam logic [2:0] ST_EOF_PAY  = 3'd5;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;
  localparam logic [1:0] KIND_REAL = 2'd2;
  localparam logic [1:0] KIND_CHAR = 2'd3;

  localparam logic [7:0] DT_BITS   = 8'd1;
  localparam logic [7:0] DT_SHORT  = 8'd2;
  localparam logic [7:0] DT_LONG   = 8'd3;
  localparam logic [7:0] DT_SGL    = 8'd4;
  localparam logic [7:0] DT_DBL    = 8'd5;
  localparam logic [7:0] DT_STRING = 8'd6;

  localparam logic [10:0] EXP_BIAS_ADJ = 11'd711;

  typedef enum logic [1:0] {
    FMT_INT,
    FMT_R32,
    FMT_R64,
    FMT_CHAR
  } fmt_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'b01,
    PH_PAYLOAD = 2'b10
  } phase_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] element_value;
    logic [1:0]  value_kind;
    logic [14:0] element_index;
    logic [15:0] record_length;
  } out_item_t;

  typedef struct packed {
    logic        emit_elem;
    fmt_t        fmt;
    logic [63:0] raw;
    logic [14:0] elem_idx;
    logic        tail_valid;
    logic [2:0]  tail_status;
    logic [14:0] tail_idx;
    logic [15:0] rec_len;
  } q_entry_t;

endpackage

// ----- hw/rtl/gdsrd_front.sv -----
`timescale 1ns / 1ps

module gdsrd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  gdsrd_pkg::in_item_t item,
  input  logic                cfg_valid,
  input  logic [15:0]         cfg_data,
  output logic                push,
  output gdsrd_pkg::q_entry_t entry
);
  import gdsrd_pkg::*;

  logic [15:0] exp_id_r;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  hb_r, hb_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] left_r, left_nxt;
  logic [63:0] buf_r, buf_nxt;
  logic [2:0]  ecnt_r, ecnt_nxt;
  logic [14:0] ctr_r, ctr_nxt;
  logic        term_r, term_nxt;

  always_comb begin
    logic [7:0]  b;
    logic [63:0] sh;
    logic [3:0]  size;
    logic        coll;
    logic        done;
    logic [15:0] left_d;
    b = item.data_byte;
    sh = {buf_r[55:0], b};
    size = 4'd0;
    coll = 1'b0;
    done = 1'b0;
    left_d = left_r - 16'd1;
    phase_nxt = phase_r;
    hb_nxt = hb_r;
    len_nxt = len_r;
    id_nxt = id_r;
    left_nxt = left_r;
    buf_nxt = buf_r;
    ecnt_nxt = ecnt_r;
    ctr_nxt = ctr_r;
    term_nxt = term_r;
    push = 1'b0;
    entry = '0;
    entry.rec_len = len_r;
    if (acc) begin
      if (item.command) begin
        push = 1'b1;
        entry.tail_valid = 1'b1;
        if (phase_r == PH_PAYLOAD) begin
          entry.tail_status = ST_EOF_PAY;
          entry.tail_idx = ctr_r;
        end else begin
          entry.tail_status = ST_EOF_HDR;
          entry.rec_len = '0;
        end
        phase_nxt = PH_HEADER;
        hb_nxt = '0;
        len_nxt = '0;
        id_nxt = '0;
        left_nxt = '0;
        buf_nxt = '0;
        ecnt_nxt = '0;
        ctr_nxt = '0;
        term_nxt = 1'b0;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (hb_r < 2'd2) begin
              len_nxt = {len_r[7:0], b};
            end else begin
              id_nxt = {id_r[7:0], b};
            end
            if (hb_r != 2'd3) begin
              hb_nxt = hb_r + 2'd1;
            end else begin
              hb_nxt = '0;
              buf_nxt = '0;
              ecnt_nxt = '0;
              ctr_nxt = '0;
              term_nxt = 1'b0;
              push = 1'b1;
              entry.tail_valid = 1'b1;
              if (id_nxt != exp_id_r) begin
                entry.tail_status = ST_MISMATCH;
              end else if (len_r < 16'd4) begin
                entry.tail_status = ST_BADLEN;
              end else if (len_r == 16'd4) begin
                entry.tail_status = ST_END;
              end else begin
                push = 1'b0;
                phase_nxt = PH_PAYLOAD;
                left_nxt = len_r - 16'd4;
              end
            end
          end
          PH_PAYLOAD: begin
            left_nxt = left_d;
            entry.elem_idx = ctr_r;
            case (id_r[7:0])
              DT_BITS: begin
                coll = (ctr_r == '0);
                size = 4'd2;
                entry.fmt = FMT_INT;
                entry.raw = {48'd0, sh[15:0]};
              end
              DT_SHORT: begin
                coll = 1'b1;
                size = 4'd2;
                entry.fmt = FMT_INT;
                entry.raw = {{48{sh[15]}}, sh[15:0]};
              end
              DT_LONG: begin
                coll = 1'b1;
                size = 4'd4;
                entry.fmt = FMT_INT;
                entry.raw = {{32{sh[31]}}, sh[31:0]};
              end
              DT_SGL: begin
                coll = 1'b1;
                size = 4'd4;
                entry.fmt = FMT_R32;
                entry.raw = sh;
              end
              DT_DBL: begin
                coll = 1'b1;
                size = 4'd8;
                entry.fmt = FMT_R64;
                entry.raw = sh;
              end
              DT_STRING: begin
                entry.fmt = FMT_CHAR;
                entry.raw = {56'd0, b};
                if (!term_r) begin
                  if (b == 8'd0) begin
                    term_nxt = 1'b1;
                  end else begin
                    done = 1'b1;
                  end
                end
              end
              default: begin
                entry.fmt = FMT_INT;
              end
            endcase
            if (coll) begin
              buf_nxt = sh;
              if ({1'b0, ecnt_r} + 4'd1 >= size) begin
                ecnt_nxt = '0;
                done = 1'b1;
              end else begin
                ecnt_nxt = ecnt_r + 3'd1;
              end
            end
            if (done) begin
              buf_nxt = '0;
              ctr_nxt = ctr_r + 15'd1;
            end
            entry.emit_elem = done;
            if (left_d == '0) begin
              entry.tail_valid = 1'b1;
              entry.tail_status = ST_END;
              entry.tail_idx = ctr_nxt;
              phase_nxt = PH_HEADER;
              buf_nxt = '0;
              ecnt_nxt = '0;
            end
            push = done | (left_d == '0);
          end
          default: begin
            phase_nxt = PH_HEADER;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r <= '0;
      phase_r <= PH_HEADER;
      hb_r <= '0;
      len_r <= '0;
      id_r <= '0;
      left_r <= '0;
      buf_r <= '0;
      ecnt_r <= '0;
      ctr_r <= '0;
      term_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        exp_id_r <= cfg_data;
      end
      phase_r <= phase_nxt;
      hb_r <= hb_nxt;
      len_r <= len_nxt;
      id_r <= id_nxt;
      left_r <= left_nxt;
      buf_r <= buf_nxt;
      ecnt_r <= ecnt_nxt;
      ctr_r <= ctr_nxt;
      term_r <= term_nxt;
    end
  end

endmodule

// ----- hw/rtl/gdsrd_queue.sv -----
`timescale 1ns / 1ps

module gdsrd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gdsrd_pkg::q_entry_t wdata,
  input  logic                pop,
  output gdsrd_pkg::q_entry_t rdata,
  output logic                empty,
  output logic                full
);
  import gdsrd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign empty = (cnt_r == '0);
  assign full = (cnt_r == CW'(DEPTH));
  assign rdata = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("request pushed into a full queue");
`endif

endmodule

// ----- hw/rtl/gdsrd_back.sv -----
`timescale 1ns / 1ps

module gdsrd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gdsrd_pkg::q_entry_t  q_data,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gdsrd_pkg::out_item_t out_data
);
  import gdsrd_pkg::*;

  q_entry_t    s1_r;
  logic        s1_v_r;
  logic [5:0]  s1_lz_r;
  logic        s1_zero_r;

  out_item_t   s2_elem_r, s2_tail_r;
  logic        s2_emit_r, s2_tvalid_r, s2_v_r;

  out_item_t   out_r, pend_item_r;
  logic        out_v_r, pend_r;

  logic        out_take, out_load_ok, s2_move, s1_move;
  logic [55:0] q_mant;
  logic [5:0]  q_lz;
  out_item_t   elem_c, tail_c;

  assign out_take = out_v_r && !out_stall;
  assign out_load_ok = !out_v_r || (out_take && !pend_r);
  assign s2_move = s2_v_r && out_load_ok;
  assign s1_move = s1_v_r && (!s2_v_r || s2_move);
  assign q_pop = !q_empty && (!s1_v_r || s1_move);

  always_comb begin
    q_mant = (q_data.fmt == FMT_R32) ? {q_data.raw[23:0], 32'd0} : q_data.raw[55:0];
    q_lz = 6'd55;
    for (int i = 0; i < 56; i++) begin
      if (q_mant[i]) begin
        q_lz = 6'(55 - i);
      end
    end
  end

  always_comb begin
    logic [55:0] mant;
    logic [55:0] norm;
    logic [53:0] rnd;
    logic        up;
    logic [6:0]  ex;
    logic        sgn;
    logic [10:0] bexp;
    if (s1_r.fmt == FMT_R32) begin
      mant = {s1_r.raw[23:0], 32'd0};
      ex = s1_r.raw[30:24];
      sgn = s1_r.raw[31];
    end else begin
      mant = s1_r.raw[55:0];
      ex = s1_r.raw[62:56];
      sgn = s1_r.raw[63];
    end
    norm = mant << s1_lz_r;
    up = norm[2] && (norm[1] || norm[0] || norm[3]);
    rnd = {1'b0, norm[55:3]} + {53'd0, up};
    bexp = 11'(6'd55 - s1_lz_r) + {2'b00, ex, 2'b00} + EXP_BIAS_ADJ + {10'd0, rnd[53]};
    elem_c.status = ST_ELEM;
    elem_c.element_index = s1_r.elem_idx;
    elem_c.record_length = s1_r.rec_len;
    elem_c.element_value = s1_r.raw;
    elem_c.value_kind = KIND_INT;
    case (s1_r.fmt)
      FMT_R32, FMT_R64: begin
        elem_c.value_kind = KIND_REAL;
        if (s1_zero_r) begin
          elem_c.element_value = {sgn, 63'd0};
        end else if (rnd[53]) begin
          elem_c.element_value = {sgn, bexp, 52'd0};
        end else begin
          elem_c.element_value = {sgn, bexp, rnd[51:0]};
        end
      end
      FMT_CHAR: elem_c.value_kind = KIND_CHAR;
      default: elem_c.value_kind = KIND_INT;
    endcase
    tail_c.status = s1_r.tail_status;
    tail_c.element_value = '0;
    tail_c.value_kind = KIND_NONE;
    tail_c.element_index = s1_r.tail_idx;
    tail_c.record_length = s1_r.rec_len;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r <= q_data;
      s1_lz_r <= q_lz;
      s1_zero_r <= (q_mant == '0);
    end
    if (s1_move) begin
      s2_elem_r <= elem_c;
      s2_tail_r <= tail_c;
      s2_emit_r <= s1_r.emit_elem;
      s2_tvalid_r <= s1_r.tail_valid;
    end
    if (s2_move) begin
      out_r <= s2_emit_r ? s2_elem_r : s2_tail_r;
      pend_item_r <= s2_tail_r;
    end else if (out_take && pend_r) begin
      out_r <= pend_item_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      out_v_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        s2_v_r <= 1'b1;
      end else if (s2_move) begin
        s2_v_r <= 1'b0;
      end
      if (s2_move) begin
        out_v_r <= 1'b1;
        pend_r <= s2_emit_r && s2_tvalid_r;
      end else if (out_take) begin
        out_v_r <= pend_r;
        pend_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data = out_r;

`ifndef NO_ASSERTIONS
  a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_v_r)
    else $error("pending record end without a shown result");
  a_pend_is_elem: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (out_r.status == ST_ELEM))
    else $error("trailing result queued behind a non-element result");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_stall |=> out_v_r && $stable(out_r))
    else $error("stalled result changed");
`endif

endmodule

// ----- hw/rtl/gdsii_record_decoder.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall   in_data (command, data_byte)
// out      output     out_valid / out_stall out_data (status .. record_length)
// cfg      input      cfg_valid / cfg_ready cfg_data (expected record id)
//
// One byte is taken per cycle while the request queue has room.
// A result goes through the queue and the s1, s2 and out registers; a record end that
// follows an element is held pending and shown once that element is taken.
// The request queue absorbs short output stalls; when it fills, in_stall rises.
// Reset is synchronous and returns the parser to the header phase.

module gdsii_record_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gdsrd_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gdsrd_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);
  import gdsrd_pkg::*;

  logic     acc, push, q_pop, q_empty, q_full;
  q_entry_t push_entry, q_data;

  assign in_stall = q_full;
  assign acc = in_valid && !q_full;
  assign cfg_ready = 1'b1;

  gdsrd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .item      (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .push      (push),
    .entry     (push_entry)
  );

  gdsrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_entry),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty),
    .full  (q_full)
  );

  gdsrd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- verif/tb_gdsii_record_decoder.sv -----
`timescale 1ns / 1ps

module tb_gdsii_record_decoder;
  import gdsrd_pkg::*;

  class gdsii_scoreboard;
    logic [15:0] expected_id;
    bit          in_payload;
    bit [1:0]    hdr_count;
    bit [15:0]   len_r, id_r, bytes_left;
    bit [63:0]   shift_buf;
    bit [2:0]    byte_count;
    bit [14:0]   elem_count;
    bit          str_done;
    out_item_t   pending[$];
    int          errors;

    function void clear_parse();
      in_payload = 0; hdr_count = 0; len_r = 0; id_r = 0; bytes_left = 0;
      shift_buf = 0; byte_count = 0; elem_count = 0; str_done = 0;
    endfunction

    function void push(logic [2:0] st, logic [63:0] v, logic [1:0] k, logic [14:0] idx,
                       logic [15:0] len);
      out_item_t r;
      r.status = st; r.element_value = v; r.value_kind = k;
      r.element_index = idx; r.record_length = len;
      pending.insert(pending.size(), r);
    endfunction

    function bit gather(logic [7:0] b, int unsigned size);
      shift_buf = {shift_buf[55:0], b};
      if (byte_count + 1 >= size) begin
        byte_count = 0;
        return 1;
      end
      byte_count++;
      return 0;
    endfunction

    function logic [63:0] real_to_double(logic [63:0] m, int e, logic neg);
      int p, s;
      logic [63:0] frac, rem, half;
      logic [10:0] ex;
      if (m == 0) return {neg, 63'd0};
      p = 55;
      while (!m[p]) p--;
      if (p <= 52) begin
        frac = m << (52 - p);
      end else begin
        s = p - 52;
        rem = m & ((64'd1 << s) - 1);
        half = 64'd1 << (s - 1);
        frac = m >> s;
        if (rem > half || (rem == half && frac[0])) frac++;
        if (frac >> 53) begin
          frac >>= 1;
          p++;
        end
      end
      ex = 11'(p + e + 1023);
      return {neg, ex, frac[51:0]};
    endfunction

    function void note_request(in_item_t it);
      logic [63:0] v;
      logic [1:0] k;
      bit done;
      if (it.command) begin
        if (!in_payload) push(ST_EOF_HDR, 0, KIND_NONE, 0, 0);
        else push(ST_EOF_PAY, 0, KIND_NONE, elem_count, len_r);
        clear_parse();
        return;
      end
      if (!in_payload) begin
        if (hdr_count < 2) len_r = {len_r[7:0], it.data_byte};
        else id_r = {id_r[7:0], it.data_byte};
        if (hdr_count < 3) begin
          hdr_count++;
          return;
        end
        hdr_count = 0; shift_buf = 0; byte_count = 0; elem_count = 0; str_done = 0;
        if (id_r != expected_id) push(ST_MISMATCH, 0, KIND_NONE, 0, len_r);
        else if (len_r < 4) push(ST_BADLEN, 0, KIND_NONE, 0, len_r);
        else if (len_r == 4) push(ST_END, 0, KIND_NONE, 0, len_r);
        else begin
          in_payload = 1;
          bytes_left = 16'(len_r - 4);
        end
        return;
      end
      bytes_left--;
      v = 0; k = KIND_NONE; done = 0;
      case (id_r[7:0])
        DT_BITS: if (elem_count == 0 && gather(it.data_byte, 2)) begin
          v = {48'd0, shift_buf[15:0]}; k = KIND_INT; done = 1;
        end
        DT_SHORT: if (gather(it.data_byte, 2)) begin
          v = {{48{shift_buf[15]}}, shift_buf[15:0]}; k = KIND_INT; done = 1;
        end
        DT_LONG: if (gather(it.data_byte, 4)) begin
          v = {{32{shift_buf[31]}}, shift_buf[31:0]}; k = KIND_INT; done = 1;
        end
        DT_SGL: if (gather(it.data_byte, 4)) begin
          v = real_to_double({40'd0, shift_buf[23:0]}, 4 * int'(shift_buf[30:24]) - 280,
                             shift_buf[31]);
          k = KIND_REAL; done = 1;
        end
        DT_DBL: if (gather(it.data_byte, 8)) begin
          v = real_to_double({8'd0, shift_buf[55:0]}, 4 * int'(shift_buf[62:56]) - 312,
                             shift_buf[63]);
          k = KIND_REAL; done = 1;
        end
        DT_STRING: if (!str_done) begin
          if (it.data_byte == 0) str_done = 1;
          else begin
            v = {56'd0, it.data_byte}; k = KIND_CHAR; done = 1;
          end
        end
        default: ;
      endcase
      if (done) begin
        shift_buf = 0;
        push(ST_ELEM, v, k, elem_count, len_r);
        elem_count++;
      end
      if (bytes_left == 0) begin
        push(ST_END, 0, KIND_NONE, elem_count, len_r);
        in_payload = 0; shift_buf = 0; byte_count = 0;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.element_value !== want.element_value) begin
        $display("%0t: value expected %h actual %h", $time, want.element_value,
                 got.element_value);
        errors++;
      end
      if (got.value_kind !== want.value_kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, want.value_kind, got.value_kind);
        errors++;
      end
      if (got.element_index !== want.element_index) begin
        $display("%0t: index expected %0d actual %0d", $time, want.element_index,
                 got.element_index);
        errors++;
      end
      if (got.record_length !== want.record_length) begin
        $display("%0t: length expected %0d actual %0d", $time, want.record_length,
                 got.record_length);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  out_item_t   out_data;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 0;

  gdsii_scoreboard sb = new();
  int  burst_left = 0;
  int  sent = 0;
  int  idle_cycles = 0;
  int  stall_mode = 0;
  int  cyc = 0;
  logic [15:0] cur_id;

  gdsii_record_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 : (out_stall && $urandom_range(0, 7) != 0);
      default: out_stall <= cyc[2];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send(input logic cmd, input logic [7:0] b);
    in_item_t it;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    it.command = cmd;
    it.data_byte = b;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_request(it);
    sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_id(input logic [15:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.expected_id = v;
    cur_id = v;
  endtask

  task automatic send_header(input logic [15:0] len, input logic [15:0] id);
    send(0, len[15:8]); send(0, len[7:0]); send(0, id[15:8]); send(0, id[7:0]);
  endtask

  task automatic send_bytes(input logic [63:0] w, input int n);
    for (int i = n - 1; i >= 0; i--) send(0, w[i*8 +: 8]);
  endtask

  function automatic logic [7:0] payload_byte();
    if (cur_id[7:0] == DT_STRING)
      return $urandom_range(0, 15) == 0 ? 8'd0 : 8'($urandom_range(1, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_record();
    int sel, n, k;
    logic [15:0] len;
    sel = $urandom_range(0, 99);
    n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 17);
    len = 16'(n + 4);
    if (sel < 78) begin
      send_header(len, cur_id);
      repeat (n) send(0, payload_byte());
    end else if (sel < 84) begin
      send_header(16'($urandom), 16'($urandom));
    end else if (sel < 89) begin
      send_header(16'($urandom_range(0, 3)), cur_id);
    end else if (sel < 94) begin
      k = $urandom_range(0, 3);
      repeat (k) send(0, 8'($urandom));
      send(1, 8'($urandom));
    end else begin
      send_header(16'(len + 1), cur_id);
      repeat (n) send(0, payload_byte());
      send(1, 8'($urandom));
    end
  endtask

  initial begin
    logic [15:0] phase_ids[$];
    cur_id = 0;
    sb.expected_id = 0;
    sb.clear_parse();
    sb.errors = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_id(16'h1002);
    send(1, 8'h00);
    send_header(16'd4, 16'h1002);
    send_header(16'd0, 16'h1002);
    send_header(16'd3, 16'h1002);
    send_header(16'd8, 16'h1003);
    send_header(16'd9, 16'h1002);
    send_bytes(64'h8000_7FFF_FF, 5);
    send(0, 8'h00); send(0, 8'h0C); send(1, 8'hFF);
    write_id(16'h0005);
    send_header(16'd28, 16'h0005);
    send_bytes(64'h8000_0000_0000_0000, 8);
    send_bytes(64'hFFFF_FFFF_FFFF_FFFF, 8);
    send_bytes(64'h4110_0000_0000_0000, 8);
    write_id(16'h0004);
    send_header(16'd16, 16'h0004);
    send_bytes(64'h4110_0000, 4);
    send_bytes(64'h7FFF_FFFF, 4);
    send_bytes(64'h8000_0000, 4);
    send_bytes(64'h0000_0001, 4);
    write_id(16'h0006);
    send_header(16'd9, 16'h0006);
    send_bytes(64'h41FF_0042_43, 5);

    phase_ids = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003, 16'h0004,
                  16'h0005, 16'h0006, 16'h0007};
    while (sent < 1100) begin
      foreach (phase_ids[i]) begin
        if (i >= 2) phase_ids[i][15:8] = 8'($urandom);
        write_id(phase_ids[i]);
        repeat ($urandom_range(4, 10)) if (sent < 1100) random_record();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/gdsrd_pkg.sv
hw/rtl/gdsrd_front.sv
hw/rtl/gdsrd_queue.sv
hw/rtl/gdsrd_back.sv
hw/rtl/gdsii_record_decoder.sv
verif/tb_gdsii_record_decoder.sv
